// ----- design/babur_pkg.sv -----
package babur_pkg;

	localparam int OpW      = 3;
	localparam int PosW     = 32;
	localparam int LenW     = 16;
	localparam int SizeW    = 16;
	localparam int BytesW   = 24;
	localparam int TmoW     = 24;
	localparam int RetryW   = 8;
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 24;
	// ms counters saturate at 2**TmoW, which already exceeds every limit
	localparam int MsCntW   = TmoW + 1;
	// accepted blocks only matter as 0, 1 or "two or more"
	localparam int AbW      = 2;
	localparam int DivBits  = BytesW;
	localparam int DivCntW  = $clog2(DivBits);

	localparam logic [TmoW-1:0]   RstFirstTmo  = TmoW'(5000);
	localparam logic [TmoW-1:0]   RstBlockTmo  = TmoW'(2000);
	localparam logic [RetryW-1:0] RstMaxRetry  = RetryW'(5);
	localparam logic [TmoW-1:0]   RstOverall   = TmoW'(1800000);
	localparam logic [SizeW-1:0]  RstDefBlock  = SizeW'(5000);
	localparam logic [SizeW-1:0]  RstDefBatch  = SizeW'(40);
	localparam logic [BytesW-1:0] RstMaxBytes  = BytesW'(100000);
	localparam logic [SizeW-1:0]  RstChanLimit = '0;

	typedef enum logic [OpW-1:0] {
		OP_START  = 3'd0,
		OP_BLOCK  = 3'd1,
		OP_TICK   = 3'd2,
		OP_END    = 3'd3,
		OP_CANCEL = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		SS_NONE     = 2'd0,
		SS_ACCEPTED = 2'd1,
		SS_REFUSED  = 2'd2
	} start_status_t;

	typedef enum logic [2:0] {
		CR_NONE       = 3'd0,
		CR_UNEXPECTED = 3'd1,
		CR_RETRIES    = 3'd2,
		CR_TIMEOUT    = 3'd3,
		CR_HOST       = 3'd4
	} cancel_reason_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_FIRST_TMO  = 3'd0,
		REG_BLOCK_TMO  = 3'd1,
		REG_MAX_RETRY  = 3'd2,
		REG_OVERALL    = 3'd3,
		REG_DEF_BLOCK  = 3'd4,
		REG_DEF_BATCH  = 3'd5,
		REG_MAX_BYTES  = 3'd6,
		REG_CHAN_LIMIT = 3'd7
	} reg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_MUL,
		S_DIV,
		S_FIN
	} state_t;

	typedef struct packed {
		logic [OpW-1:0]   opcode;
		logic [PosW-1:0]  file_pos;
		logic [LenW-1:0]  block_len;
		logic [PosW-1:0]  file_size;
		logic [SizeW-1:0] host_block_size;
		logic [SizeW-1:0] host_batch_size;
	} in_item_t;

	typedef struct packed {
		logic [1:0]       start_status;
		logic             ack_due;
		logic [PosW-1:0]  ok_to;
		logic             block_valid;
		logic             first_block;
		logic             final_block;
		logic [2:0]       cancel_reason;
		logic             ended_ok;
		logic [SizeW-1:0] block_size_used;
		logic [SizeW-1:0] batch_size_used;
		logic             active;
	} out_item_t;

	typedef struct packed {
		logic latch_in;
		logic size_load;
		logic div_start;
		logic exec_commit;
		logic start_commit;
	} dp_cmd_t;

	typedef struct packed {
		logic is_start;
		logic refused;
		logic over_limit;
		logic div_done;
		logic out_free;
	} dp_stat_t;

endpackage

// ----- design/babur_chan_if.sv -----
interface babur_chan_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ----- design/babur_div.sv -----
module babur_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [babur_pkg::BytesW-1:0]  dividend,
	input  logic [babur_pkg::SizeW-1:0]   divisor,
	output logic [babur_pkg::SizeW-1:0]   quotient,
	output logic                          done
);
	import babur_pkg::*;

	logic [BytesW-1:0]  dq_q;
	logic [SizeW-1:0]   rem_q;
	logic [DivCntW-1:0] cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [SizeW:0]     trial;
	logic [SizeW:0]     diff;
	logic               ge;
	logic [SizeW-1:0]   rem_n;

	// restoring division, one quotient bit per cycle
	assign trial = {rem_q, dq_q[BytesW-1]};
	assign diff  = trial - {1'b0, divisor};
	assign ge    = trial >= {1'b0, divisor};
	assign rem_n = ge ? diff[SizeW-1:0] : trial[SizeW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + DivCntW'(1);
			if (cnt_q == DivCntW'(DivBits - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dq_q  <= {dq_q[BytesW-2:0], ge};
			rem_q <= rem_n;
		end
	end

	// the caller only divides when the quotient fits the size width
	assign quotient = dq_q[SizeW-1:0];
	assign done     = done_q;
endmodule

// ----- design/babur_ctrl.sv -----
module babur_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  babur_pkg::dp_stat_t  stat,
	output babur_pkg::dp_cmd_t   cmd
);
	import babur_pkg::*;

	state_t state_q;
	state_t state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_n = S_EXEC;
			end
			S_EXEC: begin
				if (stat.is_start && !stat.refused) begin
					state_n = S_MUL;
				end else if (stat.out_free) begin
					state_n = S_IDLE;
				end
			end
			S_MUL: begin
				state_n = stat.over_limit ? S_DIV : S_FIN;
			end
			S_DIV: begin
				if (stat.div_done) state_n = S_FIN;
			end
			S_FIN: begin
				if (stat.out_free) state_n = S_IDLE;
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready         = 1'b0;
		cmd              = '0;
		unique case (state_q)
			S_IDLE: begin
				in_ready     = 1'b1;
				cmd.latch_in = in_valid;
			end
			S_EXEC: begin
				if (stat.is_start && !stat.refused) begin
					cmd.size_load = 1'b1;
				end else begin
					cmd.exec_commit = stat.out_free;
				end
			end
			S_MUL: begin
				cmd.div_start = stat.over_limit;
			end
			S_DIV: begin
			end
			S_FIN: begin
				cmd.start_commit = stat.out_free;
			end
			default: begin
			end
		endcase
	end
endmodule

// ----- design/babur_dp.sv -----
module babur_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [babur_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [babur_pkg::CfgDataW-1:0]  cfg_data,
	input  babur_pkg::in_item_t             in_data,
	output babur_pkg::out_item_t            out_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	input  babur_pkg::dp_cmd_t              cmd,
	output babur_pkg::dp_stat_t             stat
);
	import babur_pkg::*;

	// configuration
	logic [TmoW-1:0]   first_tmo_q;
	logic [TmoW-1:0]   block_tmo_q;
	logic [RetryW-1:0] max_retry_q;
	logic [TmoW-1:0]   overall_q;
	logic [SizeW-1:0]  def_blk_q;
	logic [SizeW-1:0]  def_bat_q;
	logic [BytesW-1:0] max_bytes_q;
	logic [SizeW-1:0]  chan_lim_q;

	// upload state
	logic              active_q;
	logic [PosW-1:0]   exp_q;
	logic [AbW-1:0]    ab_q;
	logic [SizeW-1:0]  batch_q;
	logic [RetryW-1:0] retry_q;
	logic [MsCntW-1:0] since_last_q;
	logic [MsCntW-1:0] since_start_q;
	logic [PosW-1:0]   total_q;
	logic [SizeW-1:0]  blk_size_q;
	logic [SizeW-1:0]  bat_size_q;

	// working registers
	in_item_t          item_q;
	logic [SizeW-1:0]  blk_c_q;
	logic [SizeW-1:0]  bat_c_q;
	out_item_t         out_q;
	logic              out_valid_q;

	logic [SizeW-1:0]  blk_sel;
	logic [SizeW-1:0]  bat_sel;
	logic [2*SizeW-1:0] prod;
	logic [SizeW-1:0]  quo;
	logic              div_done;

	logic              act_n;
	logic [PosW-1:0]   exp_n;
	logic [AbW-1:0]    ab_n;
	logic [SizeW-1:0]  batch_n;
	logic [RetryW-1:0] retry_n;
	logic [MsCntW-1:0] sl_n;
	logic [MsCntW-1:0] ss_n;
	out_item_t         res;

	logic [SizeW-1:0]  bb_inc;
	logic              match;
	logic [PosW:0]     pos_end;
	logic [AbW-1:0]    ab_inc;
	logic [MsCntW-1:0] sl_inc;
	logic [MsCntW-1:0] ss_inc;
	logic [TmoW-1:0]   limit;
	logic [RetryW-1:0] rc_inc;
	logic              commit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_tmo_q <= RstFirstTmo;
			block_tmo_q <= RstBlockTmo;
			max_retry_q <= RstMaxRetry;
			overall_q   <= RstOverall;
			def_blk_q   <= RstDefBlock;
			def_bat_q   <= RstDefBatch;
			max_bytes_q <= RstMaxBytes;
			chan_lim_q  <= RstChanLimit;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_FIRST_TMO:  first_tmo_q <= cfg_data[TmoW-1:0];
				REG_BLOCK_TMO:  block_tmo_q <= cfg_data[TmoW-1:0];
				REG_MAX_RETRY:  max_retry_q <= cfg_data[RetryW-1:0];
				REG_OVERALL:    overall_q   <= cfg_data[TmoW-1:0];
				REG_DEF_BLOCK:  def_blk_q   <= cfg_data[SizeW-1:0];
				REG_DEF_BATCH:  def_bat_q   <= cfg_data[SizeW-1:0];
				REG_MAX_BYTES:  max_bytes_q <= cfg_data[BytesW-1:0];
				REG_CHAN_LIMIT: chan_lim_q  <= cfg_data[SizeW-1:0];
				default: begin
				end
			endcase
		end
	end

	// start negotiation: defaults, then channel clamp
	always_comb begin
		if (item_q.host_block_size != '0) begin
			blk_sel = item_q.host_block_size;
		end else if (def_blk_q != '0) begin
			blk_sel = def_blk_q;
		end else begin
			blk_sel = SizeW'(1);
		end
		if (chan_lim_q != '0 && blk_sel > chan_lim_q) blk_sel = chan_lim_q;
		if (item_q.host_batch_size != '0) begin
			bat_sel = item_q.host_batch_size;
		end else if (def_bat_q != '0) begin
			bat_sel = def_bat_q;
		end else begin
			bat_sel = SizeW'(1);
		end
	end

	assign prod = {{SizeW{1'b0}}, blk_c_q} * {{SizeW{1'b0}}, bat_c_q};

	babur_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (max_bytes_q),
		.divisor  (blk_c_q),
		.quotient (quo),
		.done     (div_done)
	);

	always_ff @(posedge clk) begin
		if (cmd.latch_in) item_q <= in_data;
		if (cmd.size_load) begin
			blk_c_q <= blk_sel;
			bat_c_q <= bat_sel;
		end else if (div_done) begin
			bat_c_q <= (quo == '0) ? SizeW'(1) : quo;
		end
	end

	assign bb_inc  = batch_q + SizeW'(1);
	assign match   = item_q.file_pos == exp_q;
	assign pos_end = {1'b0, item_q.file_pos} + (PosW+1)'(item_q.block_len);
	assign ab_inc  = (ab_q == AbW'(2)) ? ab_q : ab_q + AbW'(1);
	assign sl_inc  = since_last_q[MsCntW-1] ? since_last_q : since_last_q + MsCntW'(1);
	assign ss_inc  = since_start_q[MsCntW-1] ? since_start_q : since_start_q + MsCntW'(1);
	assign limit   = (ab_q < AbW'(2)) ? first_tmo_q : block_tmo_q;
	assign rc_inc  = (retry_q == '1) ? retry_q : retry_q + RetryW'(1);

	always_comb begin
		act_n   = active_q;
		exp_n   = exp_q;
		ab_n    = ab_q;
		batch_n = batch_q;
		retry_n = retry_q;
		sl_n    = since_last_q;
		ss_n    = since_start_q;
		res     = '0;
		if (cmd.start_commit) begin
			act_n            = 1'b1;
			exp_n            = '0;
			ab_n             = '0;
			batch_n          = '0;
			retry_n          = '0;
			sl_n             = '0;
			ss_n             = '0;
			res.start_status = SS_ACCEPTED;
		end else begin
			unique case (op_t'(item_q.opcode))
				OP_START: begin
					res.start_status = SS_REFUSED;
				end
				OP_BLOCK: begin
					if (!active_q) begin
						res.cancel_reason = CR_UNEXPECTED;
					end else begin
						// a misplaced block still counts toward the batch
						sl_n    = '0;
						retry_n = '0;
						if (match) begin
							res.block_valid = 1'b1;
							exp_n           = exp_q + PosW'(item_q.block_len);
							ab_n            = ab_inc;
							res.first_block = item_q.file_pos == '0;
							res.final_block = pos_end >= {1'b0, total_q};
						end
						if (bb_inc == bat_size_q || ab_n == AbW'(1) || res.final_block) begin
							res.ack_due = 1'b1;
							batch_n     = '0;
						end else begin
							batch_n = bb_inc;
						end
					end
				end
				OP_TICK: begin
					if (active_q) begin
						sl_n = sl_inc;
						ss_n = ss_inc;
						if (sl_inc > {1'b0, limit}) begin
							retry_n = rc_inc;
							if (rc_inc < max_retry_q) begin
								sl_n        = '0;
								res.ack_due = 1'b1;
							end else begin
								act_n             = 1'b0;
								res.cancel_reason = CR_RETRIES;
							end
						end
						// overall timeout only when the retry path did nothing
						if (!res.ack_due && res.cancel_reason == CR_NONE &&
								ss_inc > {1'b0, overall_q}) begin
							act_n             = 1'b0;
							res.cancel_reason = CR_TIMEOUT;
						end
					end
				end
				OP_END: begin
					res.ended_ok = 1'b1;
					act_n        = 1'b0;
				end
				OP_CANCEL: begin
					res.cancel_reason = CR_HOST;
					act_n             = 1'b0;
				end
				default: begin
				end
			endcase
		end
		res.ok_to           = exp_n;
		res.block_size_used = cmd.start_commit ? blk_c_q : blk_size_q;
		res.batch_size_used = cmd.start_commit ? bat_c_q : bat_size_q;
		res.active          = act_n;
	end

	assign commit = cmd.exec_commit || cmd.start_commit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q      <= 1'b0;
			exp_q         <= '0;
			ab_q          <= '0;
			batch_q       <= '0;
			retry_q       <= '0;
			since_last_q  <= '0;
			since_start_q <= '0;
			total_q       <= '0;
			blk_size_q    <= RstDefBlock;
			bat_size_q    <= RstDefBatch;
			out_valid_q   <= 1'b0;
		end else begin
			if (commit) begin
				active_q      <= act_n;
				exp_q         <= exp_n;
				ab_q          <= ab_n;
				batch_q       <= batch_n;
				retry_q       <= retry_n;
				since_last_q  <= sl_n;
				since_start_q <= ss_n;
			end
			if (cmd.start_commit) begin
				total_q    <= item_q.file_size;
				blk_size_q <= blk_c_q;
				bat_size_q <= bat_c_q;
			end
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) out_q <= res;
	end

	assign out_data = out_q;
	assign out_valid = out_valid_q;

	assign stat.is_start   = item_q.opcode == OP_START;
	assign stat.refused    = active_q && exp_q != '0;
	assign stat.over_limit = prod > (2*SizeW)'(max_bytes_q);
	assign stat.div_done   = div_done;
	assign stat.out_free   = !out_valid_q || out_ready;
endmodule

// ----- design/batch_ack_block_upload_receiver.sv -----
// channel   role    handshake      payload
// items     sink    valid/ready    opcode, file_pos, block_len, file_size, host sizes
// results   source  valid/ready    one result per item, see out_item_t
// cfg       write   cfg_we         cfg_index selects the register, cfg_data the value
//
// Block, tick, end, cancel, unused and refused start items are accepted in S_IDLE and
// executed in S_EXEC, which loads the output register. An accepted start passes S_IDLE,
// S_EXEC, S_MUL and S_FIN, plus S_DIV when the batch must be cut down by the 24-step
// serial divider for max_batch_bytes / block size. A result waiting in the output
// register does not block the next accept; execution stalls only until it is free.
// Reset sets control, upload and config state but not the data registers; no sweep needed.
module batch_ack_block_upload_receiver (
	input  logic                            clk,
	input  logic                            arst_n,
	babur_chan_if.sink                      items,
	babur_chan_if.source                    results,
	input  logic                            cfg_we,
	input  logic [babur_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [babur_pkg::CfgDataW-1:0]  cfg_data
);
	import babur_pkg::*;

	dp_cmd_t   cmd;
	dp_stat_t  stat;
	logic      in_ready;
	logic      out_valid;
	out_item_t out_data;

	babur_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (items.valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	babur_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (items.payload),
		.out_data  (out_data),
		.out_valid (out_valid),
		.out_ready (results.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	assign items.ready     = in_ready;
	assign results.valid   = out_valid;
	assign results.payload = out_data;
endmodule

// ----- design/babur_check.sv -----
module babur_check (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input babur_pkg::out_item_t out_data
);
	import babur_pkg::*;

	logic [1:0] pend_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// transactions accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (in_acc && !out_acc) begin
			pend_q <= pend_q + 2'd1;
		end else if (out_acc && !in_acc) begin
			pend_q <= pend_q - 2'd1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed or dropped while stalled");

	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 2'd0)
		else $error("result without an accepted item");

	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 2'd2)
		else $error("more than two items in flight");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ready)
		else $error("accepted an item while one is executing");
endmodule

bind batch_ack_block_upload_receiver babur_check u_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (items.valid),
	.in_ready  (items.ready),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.out_data  (results.payload)
);

// ----- test/upload_checker.sv -----
module upload_checker import babur_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	input  logic                item_ready,
	input  in_item_t            item,
	input  logic                res_valid,
	input  logic                res_ready,
	input  out_item_t           res,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	output int                  pending,
	output int                  checked,
	output int                  errors
);
	timeunit 1ns;
	timeprecision 1ps;

	// register copies
	logic [TmoW-1:0]   lim_first, lim_block, lim_overall;
	logic [RetryW-1:0] retry_max;
	logic [SizeW-1:0]  dflt_block, dflt_batch, chan_limit;
	logic [BytesW-1:0] batch_bytes_max;

	// upload state
	logic              up_active;
	logic [PosW-1:0]   next_pos, file_len;
	logic [31:0]       blocks_ok, quiet_ms, elapsed_ms;
	logic [SizeW-1:0]  batch_cnt, blk_size, bat_size;
	logic [RetryW-1:0] retries;

	out_item_t reply_q[$];
	int        fails;
	int        n_checked;

	task automatic upload_reply(input in_item_t it, output out_item_t r);
		logic [SizeW-1:0] blk, bat;
		logic [31:0]      prod, lim;
		logic [PosW:0]    reach;
		r = '0;
		case (it.opcode)
			OP_START: begin
				if (up_active && next_pos != 0) begin
					r.start_status = SS_REFUSED;
				end else begin
					r.start_status = SS_ACCEPTED;
					file_len   = it.file_size;
					up_active  = 1'b1;
					quiet_ms   = '0;
					elapsed_ms = '0;
					blocks_ok  = '0;
					next_pos   = '0;
					batch_cnt  = '0;
					retries    = '0;
					blk = it.host_block_size;
					if (blk == 0) blk = dflt_block;
					if (blk == 0) blk = 1;
					bat = it.host_batch_size;
					if (bat == 0) bat = dflt_batch;
					if (bat == 0) bat = 1;
					if (chan_limit != 0 && blk > chan_limit) blk = chan_limit;
					prod = 32'(blk) * 32'(bat);
					if (prod > 32'(batch_bytes_max)) begin
						bat = SizeW'(32'(batch_bytes_max) / 32'(blk));
						if (bat == 0) bat = 1;
					end
					blk_size = blk;
					bat_size = bat;
				end
			end
			OP_BLOCK: begin
				if (!up_active) begin
					r.cancel_reason = CR_UNEXPECTED;
				end else begin
					// a misplaced block still counts toward the batch
					batch_cnt = batch_cnt + 1'b1;
					quiet_ms  = '0;
					if (it.file_pos == next_pos) begin
						r.block_valid = 1'b1;
						next_pos = next_pos + PosW'(it.block_len);
						if (blocks_ok != '1) blocks_ok = blocks_ok + 1;
						r.first_block = (it.file_pos == 0);
						reach = {1'b0, it.file_pos} + (PosW+1)'(it.block_len);
						r.final_block = (reach >= {1'b0, file_len});
					end
					if (batch_cnt == bat_size || blocks_ok == 1 || r.final_block) begin
						batch_cnt = '0;
						r.ack_due = 1'b1;
					end
					retries = '0;
				end
			end
			OP_TICK: begin
				if (up_active) begin
					if (quiet_ms != '1) quiet_ms = quiet_ms + 1;
					if (elapsed_ms != '1) elapsed_ms = elapsed_ms + 1;
					lim = (blocks_ok < 2) ? 32'(lim_first) : 32'(lim_block);
					if (quiet_ms > lim) begin
						if (retries != '1) retries = retries + 1'b1;
						if (retries < retry_max) begin
							quiet_ms = '0;
							r.ack_due = 1'b1;
						end else begin
							up_active = 1'b0;
							r.cancel_reason = CR_RETRIES;
						end
					end
					// retry exhaustion wins over the overall timeout on the same tick
					if (!r.ack_due && r.cancel_reason == CR_NONE &&
							elapsed_ms > 32'(lim_overall)) begin
						up_active = 1'b0;
						r.cancel_reason = CR_TIMEOUT;
					end
				end
			end
			OP_END: begin
				r.ended_ok = 1'b1;
				up_active = 1'b0;
			end
			OP_CANCEL: begin
				r.cancel_reason = CR_HOST;
				up_active = 1'b0;
			end
			default: ;
		endcase
		r.ok_to           = next_pos;
		r.block_size_used = blk_size;
		r.batch_size_used = bat_size;
		r.active          = up_active;
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			fails++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t want, pred;
		if (!arst_n) begin
			lim_first       = RstFirstTmo;
			lim_block       = RstBlockTmo;
			retry_max       = RstMaxRetry;
			lim_overall     = RstOverall;
			dflt_block      = RstDefBlock;
			dflt_batch      = RstDefBatch;
			batch_bytes_max = RstMaxBytes;
			chan_limit      = RstChanLimit;
			up_active       = 1'b0;
			next_pos        = '0;
			file_len        = '0;
			blocks_ok       = '0;
			quiet_ms        = '0;
			elapsed_ms      = '0;
			batch_cnt       = '0;
			retries         = '0;
			blk_size        = SizeW'(5000);
			bat_size        = SizeW'(40);
			reply_q.delete();
			fails     = 0;
			n_checked = 0;
		end else begin
			// compare before predicting so an early result cannot match its own item
			if (res_valid && res_ready) begin
				if (reply_q.size() == 0) begin
					fails++;
					$display("%0t: result with nothing expected, actual %p", $time, res);
				end else begin
					want = reply_q.pop_front();
					n_checked++;
					check_field("start_status", 32'(want.start_status), 32'(res.start_status));
					check_field("ack_due", 32'(want.ack_due), 32'(res.ack_due));
					check_field("ok_to", want.ok_to, res.ok_to);
					check_field("block_valid", 32'(want.block_valid), 32'(res.block_valid));
					check_field("first_block", 32'(want.first_block), 32'(res.first_block));
					check_field("final_block", 32'(want.final_block), 32'(res.final_block));
					check_field("cancel_reason", 32'(want.cancel_reason),
						32'(res.cancel_reason));
					check_field("ended_ok", 32'(want.ended_ok), 32'(res.ended_ok));
					check_field("block_size_used", 32'(want.block_size_used),
						32'(res.block_size_used));
					check_field("batch_size_used", 32'(want.batch_size_used),
						32'(res.batch_size_used));
					check_field("active", 32'(want.active), 32'(res.active));
				end
			end
			if (item_valid && item_ready) begin
				upload_reply(item, pred);
				reply_q.push_back(pred);
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_FIRST_TMO:  lim_first       = cfg_data[TmoW-1:0];
					REG_BLOCK_TMO:  lim_block       = cfg_data[TmoW-1:0];
					REG_MAX_RETRY:  retry_max       = cfg_data[RetryW-1:0];
					REG_OVERALL:    lim_overall     = cfg_data[TmoW-1:0];
					REG_DEF_BLOCK:  dflt_block      = cfg_data[SizeW-1:0];
					REG_DEF_BATCH:  dflt_batch      = cfg_data[SizeW-1:0];
					REG_MAX_BYTES:  batch_bytes_max = cfg_data[BytesW-1:0];
					REG_CHAN_LIMIT: chan_limit      = cfg_data[SizeW-1:0];
					default: ;
				endcase
			end
		end
		pending <= reply_q.size();
		checked <= n_checked;
		errors  <= fails;
	end
endmodule

// ----- test/tb.sv -----
module tb import babur_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WatchdogLimit = 2000;
	localparam int PhaseItems    = 50;
	localparam int NumPhases     = 8;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgDataW-1:0] cfg_data;

	babur_chan_if #(.payload_t(in_item_t))  item_ch ();
	babur_chan_if #(.payload_t(out_item_t)) res_ch ();

	int pending, checked, errors;
	bit calm;
	int n_sent, n_uploads, n_settings;
	int quiet_cycles = 0;

	batch_ack_block_upload_receiver u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.items     (item_ch),
		.results   (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	upload_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_ch.valid),
		.item_ready (item_ch.ready),
		.item       (item_ch.payload),
		.res_valid  (res_ch.valid),
		.res_ready  (res_ch.ready),
		.res        (res_ch.payload),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.pending    (pending),
		.checked    (checked),
		.errors     (errors)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		res_ch.ready <= arst_n && (calm || $urandom_range(0, 99) >= 7);
	end

	always @(posedge clk) begin
		if (!arst_n || (item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WatchdogLimit) begin
			$display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic in_item_t mk(input logic [OpW-1:0] op, input logic [PosW-1:0] pos,
			input logic [LenW-1:0] len, input logic [PosW-1:0] fsize,
			input logic [SizeW-1:0] hblk, input logic [SizeW-1:0] hbat);
		in_item_t it;
		it.opcode          = op;
		it.file_pos        = pos;
		it.block_len       = len;
		it.file_size       = fsize;
		it.host_block_size = hblk;
		it.host_batch_size = hbat;
		return it;
	endfunction

	function automatic in_item_t start_item(input logic [PosW-1:0] fsize,
			input logic [SizeW-1:0] hblk, input logic [SizeW-1:0] hbat);
		return mk(OP_START, $urandom, LenW'($urandom), fsize, hblk, hbat);
	endfunction

	function automatic in_item_t block_item(input logic [PosW-1:0] pos,
			input logic [LenW-1:0] len);
		return mk(OP_BLOCK, pos, len, $urandom, SizeW'($urandom), SizeW'($urandom));
	endfunction

	// tick, end, cancel and unused codes: the other fields are don't-care
	function automatic in_item_t ctl_item(input logic [OpW-1:0] op);
		return mk(op, $urandom, LenW'($urandom), $urandom, SizeW'($urandom), SizeW'($urandom));
	endfunction

	task automatic send(input in_item_t it);
		while (!calm && $urandom_range(0, 99) < 7) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid   <= 1'b1;
		item_ch.payload <= it;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		n_sent++;
	endtask

	// hold the sender until every outstanding result is back
	task automatic drain();
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CfgDataW-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
	endtask

	task automatic load_settings(input logic [CfgDataW-1:0] first_ms, block_ms, retry_lim,
			overall_ms, dflt_blk, dflt_bat, max_bytes, chan_lim);
		write_reg(REG_FIRST_TMO, first_ms);
		write_reg(REG_BLOCK_TMO, block_ms);
		write_reg(REG_MAX_RETRY, retry_lim);
		write_reg(REG_OVERALL, overall_ms);
		write_reg(REG_DEF_BLOCK, dflt_blk);
		write_reg(REG_DEF_BATCH, dflt_bat);
		write_reg(REG_MAX_BYTES, max_bytes);
		write_reg(REG_CHAN_LIMIT, chan_lim);
		cfg_we <= 1'b0;
		n_settings++;
	endtask

	function automatic logic [SizeW-1:0] host_size(input int hi);
		if ($urandom_range(0, 2) == 0) return '0;
		if ($urandom_range(0, 7) == 0) return SizeW'($urandom);
		return SizeW'($urandom_range(1, hi));
	endfunction

	task automatic run_upload();
		logic [PosW-1:0] pos;
		logic [PosW-1:0] fsize;
		logic [LenW-1:0] len;
		fsize = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 4000);
		send(start_item(fsize, host_size(600), host_size(12)));
		n_uploads++;
		pos = '0;
		repeat ($urandom_range(1, 14)) begin
			case ($urandom_range(0, 19))
				0:       len = LenW'($urandom);
				1:       len = '0;
				default: len = LenW'($urandom_range(1, 700));
			endcase
			if ($urandom_range(0, 9) == 0) begin
				send(block_item(pos ^ PosW'($urandom_range(1, 65535)), len));
			end else begin
				send(block_item(pos, len));
				pos = pos + PosW'(len);
			end
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 8)) send(ctl_item(OP_TICK));
			// a start in the middle of a transfer is refused while active and past position zero
			if ($urandom_range(0, 24) == 0)
				send(start_item($urandom, host_size(600), host_size(12)));
		end
		case ($urandom_range(0, 9))
			0, 1: send(ctl_item(OP_CANCEL));
			2, 3: begin
				repeat ($urandom_range(5, 60)) send(ctl_item(OP_TICK));
				send(ctl_item(OP_END));
			end
			default: send(ctl_item(OP_END));
		endcase
	endtask

	initial begin
		int phase_end;
		arst_n          = 1'b0;
		item_ch.valid   = 1'b0;
		item_ch.payload = '0;
		res_ch.ready    = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = '0;
		cfg_data        = '0;
		calm            = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset settings
		send(block_item('0, '0));
		send(ctl_item(OP_TICK));
		send(mk({OpW{1'b1}}, '1, '1, '1, '1, '1));
		send(start_item('0, '0, '0));
		send(block_item('0, '0));
		send(start_item('1, '1, '1));
		send(block_item('0, '1));
		send(start_item('0, '0, '0));
		send(block_item(PosW'(5), LenW'(7)));
		send(block_item(PosW'(16'hFFFF), '1));
		send(block_item('1, '0));
		send(ctl_item(OP_TICK));
		send(ctl_item(OP_CANCEL));
		send(ctl_item(OP_END));
		send(ctl_item(OP_END));

		// zero defaults, retry limit and overall timeout on the same tick
		drain();
		load_settings(1, 1, 1, 1, 0, 0, 24'hFFFFFF, 0);
		send(start_item(PosW'(100), '0, '0));
		repeat (2) send(ctl_item(OP_TICK));

		// channel limit and batch cut, then overall timeout alone
		drain();
		load_settings(100, 100, 5, 3, 300, 50, 1000, 200);
		send(start_item(PosW'(1000), '0, '0));
		repeat (4) send(ctl_item(OP_TICK));
		send(start_item(PosW'(1000), SizeW'(1000), SizeW'(2)));

		// walk the retry count up to a high limit
		drain();
		load_settings(1, 1, 40, 24'hFFFFFF, 5000, 40, 100000, 0);
		send(start_item(PosW'(500), '0, '0));
		repeat (82) send(ctl_item(OP_TICK));

		for (int ph = 0; ph < NumPhases; ph++) begin
			drain();
			case (ph)
				0: load_settings(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
					24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
				1: load_settings(1, 1, 1, 1, 1, 1, 1, 0);
				default: load_settings(CfgDataW'($urandom_range(1, 30)),
					CfgDataW'($urandom_range(1, 30)),
					CfgDataW'($urandom_range(1, 6)), CfgDataW'($urandom_range(20, 400)),
					($urandom_range(0, 3) == 0) ? CfgDataW'($urandom) :
						CfgDataW'($urandom_range(1, 800)),
					CfgDataW'($urandom_range(1, 60)),
					($urandom_range(0, 2) == 0) ? CfgDataW'($urandom) :
						CfgDataW'($urandom_range(1, 5000)),
					($urandom_range(0, 1) == 0) ? CfgDataW'(0) :
						CfgDataW'($urandom_range(1, 1000)));
			endcase
			calm = (ph == 3);
			phase_end = n_sent + PhaseItems;
			while (n_sent < phase_end) begin
				if ($urandom_range(0, 4) == 0)
					send(mk(OpW'($urandom), $urandom, LenW'($urandom), $urandom,
						SizeW'($urandom), SizeW'($urandom)));
				else
					run_upload();
			end
		end
		calm = 1'b0;

		drain();
		repeat (16) @(posedge clk);
		$display("Summary: %0d items sent, %0d results checked, %0d uploads, %0d settings",
			n_sent, checked, n_uploads, n_settings);
		if (errors == 0 && pending == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule

// ----- sim.f -----
design/babur_pkg.sv
design/babur_chan_if.sv
design/babur_div.sv
design/babur_ctrl.sv
design/babur_dp.sv
design/batch_ack_block_upload_receiver.sv
design/babur_check.sv
test/upload_checker.sv
test/tb.sv
